/* hdl/chunk_frustum_visibility_defines.svh */
// Assertion helpers for chunk_frustum_visibility.sv.
`ifndef CHUNK_FRUSTUM_VISIBILITY_DEFINES_SVH
`define CHUNK_FRUSTUM_VISIBILITY_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define CFV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define CFV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cfv_pkg.sv */
package cfv_pkg;

  // Chunk geometry and plane table size
  localparam int PLANE_COUNT  = 6;
  localparam int CHUNK_WIDTH  = 16;
  localparam int CHUNK_HEIGHT = 256;
  localparam int CHUNK_DEPTH  = 16;

  localparam int QSCALE = 256;
  localparam int X_SPAN = CHUNK_WIDTH * QSCALE;
  localparam int Z_SPAN = CHUNK_DEPTH * QSCALE;
  localparam int Y_TOP  = CHUNK_HEIGHT * QSCALE;

  // Datapath widths
  localparam int COORD_W = 33;               // Q.8 box corner, max corner included
  localparam int PROD_W  = 16 + COORD_W + 1; // normal times corner
  localparam int DOT_W   = PROD_W + 2;       // three terms plus offset
  localparam int GAP_W   = 33;               // camera to rectangle gap
  localparam int SQ_W    = 2 * GAP_W;
  localparam int LIM_W   = 25;               // render distance plus diagonal
  localparam int LIMSQ_W = 2 * LIM_W;

  localparam logic [23:0] RDIST_RESET = 24'd32768;

  // Elaboration-time integer square root
  function automatic int unsigned isqrt_c(input longint unsigned n);
    int unsigned     r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = longint'(r | (32'd1 << b));
      if (t * t <= n) begin
        r = r | (32'd1 << b);
      end
    end
    return r;
  endfunction

  // Chunk diagonal in Q.8, rounded down
  localparam int unsigned DIAG = isqrt_c(
      longint'(CHUNK_WIDTH * CHUNK_WIDTH + CHUNK_DEPTH * CHUNK_DEPTH) * 64'd65536);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    REASON_EMPTY  = 2'd0,
    REASON_INSIDE = 2'd1,
    REASON_NEAR   = 2'd2,
    REASON_CULLED = 2'd3
  } reason_e;

  typedef enum logic [1:0] {
    CFG_CAMERA_X   = 2'd0,
    CFG_CAMERA_Z   = 2'd1,
    CFG_RENDER_DIS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [47:0] offset;
  } plane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] z0;
    logic signed [COORD_W-1:0] z1;
  } box_t;

  // Input tdata, last field in the lowest bits
  typedef struct packed {
    logic [3:0]         pad;
    logic               occupied;
    logic signed [23:0] chunk_z;
    logic signed [23:0] chunk_x;
    logic signed [47:0] plane_offset;
    logic signed [15:0] normal_z;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_x;
    logic [2:0]         plane_index;
  } in_data_t;

  localparam int IN_DATA_W = $bits(in_data_t);

endpackage

/* hdl/chunk_frustum_visibility.sv */
// Channel  | Dir | Transfer                | Contents
// s_axis   | in  | tvalid & tready         | plane load or chunk test, opcode in tuser
// m_axis   | out | tvalid & tready         | visible, reason (tests only)
// cfg      | in  | cfg_we_i                | camera_x, camera_z, view_range
//
// One item per cycle unless the output stalls; a test result passes the input, s2, s3 and output registers.
// Four register stages: input, products/gaps, plane sums/squares, output.
// A full output register with tready low freezes every stage on one enable.
// A plane load writes the table from the input stage, so the next test sees it.
// Reset clears valid bits, the plane table and the camera registers, and sets the render distance to RDIST_RESET.
`include "chunk_frustum_visibility_defines.svh"

module chunk_frustum_visibility import cfv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // plane_index, normal_x, normal_y, normal_z, plane_offset, chunk_x, chunk_z, occupied
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,
  // opcode
  input  logic [0:0]           s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // visible, reason
  output logic [7:0]           m_axis_tdata_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  logic                       advance;
  in_data_t                   in_data;

  logic                       s1_valid_q;
  logic                       s1_test_q;
  in_data_t                   s1_data_q;
  box_t                       box;

  plane_t [PLANE_COUNT-1:0]   plane_q;
  logic signed [31:0]         cam_x_q;
  logic signed [31:0]         cam_z_q;
  logic [23:0]                rdist_q;

  logic                       s2_valid_q;
  logic                       s2_test_q;
  logic                       s2_occ_q;
  logic [GAP_W-1:0]           s2_dx_q, s2_dz_q;
  logic [LIM_W-1:0]           s2_lim_q;

  logic                       s3_valid_q;
  logic                       s3_test_q;
  logic                       s3_occ_q;
  logic                       s3_near_q;
  logic [SQ_W-1:0]            s3_dx2_q, s3_dz2_q;
  logic [LIMSQ_W-1:0]         s3_lim2_q;
  logic [PLANE_COUNT-1:0]     fail;
  logic [SQ_W:0]              dist2;

  logic                       out_valid_q;
  logic                       out_visible_q, out_visible_d;
  reason_e                    out_reason_q, out_reason_d;

  function automatic logic [GAP_W-1:0] gap_f(input logic signed [COORD_W-1:0] cam,
                                             input logic signed [COORD_W-1:0] lo,
                                             input logic signed [COORD_W-1:0] hi);
    logic signed [COORD_W:0] d_lo;
    logic signed [COORD_W:0] d_hi;
    logic [GAP_W-1:0]        g;
    d_lo = (COORD_W+1)'(lo) - (COORD_W+1)'(cam);
    d_hi = (COORD_W+1)'(cam) - (COORD_W+1)'(hi);
    if (cam < lo) begin
      g = d_lo[GAP_W-1:0];
    end else if (cam > hi) begin
      g = d_hi[GAP_W-1:0];
    end else begin
      g = '0;
    end
    return g;
  endfunction

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;
  assign in_data         = in_data_t'(s_axis_tdata_i);

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_z_q <= '0;
      rdist_q <= RDIST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAMERA_X:   cam_x_q <= cfg_data_i;
        CFG_CAMERA_Z:   cam_z_q <= cfg_data_i;
        CFG_RENDER_DIS: rdist_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // ---------------- valid pipeline ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= s_axis_tvalid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q && s3_test_q;
    end
  end

  // ---------------- plane table ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (advance && s1_valid_q && !s1_test_q) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        if (s1_data_q.plane_index == 3'(p)) begin
          plane_q[p] <= '{nx:     s1_data_q.normal_x,
                          ny:     s1_data_q.normal_y,
                          nz:     s1_data_q.normal_z,
                          offset: s1_data_q.plane_offset};
        end
      end
    end
  end

  // ---------------- stage 1: box corners ----------------
  assign box.x0 = $signed({s1_data_q.chunk_x[23], s1_data_q.chunk_x, 8'd0});
  assign box.z0 = $signed({s1_data_q.chunk_z[23], s1_data_q.chunk_z, 8'd0});
  assign box.x1 = box.x0 + COORD_W'(X_SPAN);
  assign box.z1 = box.z0 + COORD_W'(Z_SPAN);

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    cfv_plane u_plane (
      .clk_i   (clk_i),
      .en_i    (advance),
      .plane_i (plane_q[p]),
      .box_i   (box),
      .fail_o  (fail[p])
    );
  end

  // ---------------- payload stages ----------------
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_test_q <= (s_axis_tuser_i[0] == OP_TEST);
      s1_data_q <= in_data;

      s2_test_q <= s1_test_q;
      s2_occ_q  <= s1_data_q.occupied;
      s2_dx_q   <= gap_f(COORD_W'(cam_x_q), box.x0, box.x1);
      s2_dz_q   <= gap_f(COORD_W'(cam_z_q), box.z0, box.z1);
      s2_lim_q  <= LIM_W'(rdist_q) + LIM_W'(DIAG);

      s3_test_q <= s2_test_q;
      s3_occ_q  <= s2_occ_q;
      s3_near_q <= (s2_dx_q <= GAP_W'(s2_lim_q)) && (s2_dz_q <= GAP_W'(s2_lim_q));
      s3_dx2_q  <= SQ_W'(s2_dx_q) * SQ_W'(s2_dx_q);
      s3_dz2_q  <= SQ_W'(s2_dz_q) * SQ_W'(s2_dz_q);
      s3_lim2_q <= LIMSQ_W'(s2_lim_q) * LIMSQ_W'(s2_lim_q);

      out_visible_q <= out_visible_d;
      out_reason_q  <= out_reason_d;
    end
  end

  // ---------------- stage 3: decision ----------------
  assign dist2 = (SQ_W+1)'(s3_dx2_q) + (SQ_W+1)'(s3_dz2_q);

  always_comb begin
    if (!s3_occ_q) begin
      out_visible_d = 1'b0;
      out_reason_d  = REASON_EMPTY;
    end else if (fail == '0) begin
      out_visible_d = 1'b1;
      out_reason_d  = REASON_INSIDE;
    end else if (s3_near_q && dist2 <= (SQ_W+1)'(s3_lim2_q)) begin
      out_visible_d = 1'b1;
      out_reason_d  = REASON_NEAR;
    end else begin
      out_visible_d = 1'b0;
      out_reason_d  = REASON_CULLED;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_reason_q, out_visible_q};

  // ---------------- checks ----------------
  `CFV_ASSERT(a_vis_matches_reason, !out_valid_q || (out_visible_q == (out_reason_q == REASON_INSIDE || out_reason_q == REASON_NEAR)), "visible bit disagrees with reason")
  `CFV_ASSERT_NEXT(a_load_no_result, s3_valid_q && !s3_test_q && advance, !out_valid_q, "plane load produced a result")
  `CFV_ASSERT_NEXT(a_test_gives_result, s3_valid_q && s3_test_q && advance, out_valid_q, "chunk test lost its result")
  `CFV_ASSERT_NEXT(a_stall_holds, !advance, $stable(s1_valid_q) && $stable(s2_valid_q) && $stable(s3_valid_q), "pipeline moved during stall")
  `CFV_ASSERT_NEXT(a_bad_index_ignored, s1_valid_q && !s1_test_q && s1_data_q.plane_index >= 3'(PLANE_COUNT), $stable(plane_q), "out-of-range load changed the plane table")

endmodule

/* hdl/cfv_plane.sv */
// One frustum plane: positive vertex, dot product, sign test. Two stages.
module cfv_plane import cfv_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  plane_t plane_i,
  input  box_t   box_i,
  output logic   fail_o
);

  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] pz;
  logic signed [PROD_W-1:0]  prod_x_d, prod_x_q;
  logic signed [PROD_W-1:0]  prod_z_d, prod_z_q;
  logic signed [DOT_W-1:0]   base_d, base_q;
  logic signed [DOT_W-1:0]   dot;
  logic                      fail_q;

  // corner furthest along the normal; zero component takes the max side
  assign px = plane_i.nx[15] ? box_i.x0 : box_i.x1;
  assign pz = plane_i.nz[15] ? box_i.z0 : box_i.z1;

  assign prod_x_d = plane_i.nx * px;
  assign prod_z_d = plane_i.nz * pz;
  assign base_d   = (plane_i.ny[15] ? DOT_W'(0) : DOT_W'(plane_i.ny) * DOT_W'(Y_TOP))
                    + DOT_W'(plane_i.offset);

  assign dot = DOT_W'(prod_x_q) + DOT_W'(prod_z_q) + base_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= prod_x_d;
      prod_z_q <= prod_z_d;
      base_q   <= base_d;
      fail_q   <= dot[DOT_W-1];
    end
  end

  assign fail_o = fail_q;

endmodule
